>>> rtl/base64_stream_decoder_top_defines.svh
// Assertion macros used by the decoder top module.
`ifndef BASE64_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE64_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSD_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("decoder check failed");

// Next-cycle implication, disabled during reset.
`define BSD_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("decoder check failed");

`endif

>>> rtl/bsd_pkg.sv
package bsd_pkg;

  localparam int CharW   = 8;
  localparam int SextW   = 6;
  localparam int CapW    = 16;
  localparam int StatW   = 2;
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);
  localparam int TdataW  = 32;

  localparam logic [CharW-1:0] PadChar = 8'h3D;
  localparam logic [CapW-1:0]  CapReset = 16'hFFFF;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic [StatW-1:0] StatOk       = 2'd0;
  localparam logic [StatW-1:0] StatBadPad   = 2'd1;
  localparam logic [StatW-1:0] StatOverflow = 2'd2;

  typedef struct packed {
    logic              item_kind;
    logic [CharW-1:0]  data_byte;
    logic [StatW-1:0]  status_code;
    logic [CapW-1:0]   byte_total;
    logic              last_result;
  } result_t;

  typedef struct packed {
    logic    data_vld;
    result_t data_res;
    logic    stat_vld;
    result_t stat_res;
  } step_out_t;

  typedef struct packed {
    logic             hit;
    logic [SextW-1:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [CharW-1:0] ch);
    sextet_t s;
    s.hit   = 1'b1;
    s.value = '0;
    case (ch) inside
      [8'h41:8'h5A]: s.value = SextW'(ch - 8'd65);
      [8'h61:8'h7A]: s.value = SextW'(ch - 8'd71);
      [8'h30:8'h39]: s.value = SextW'(ch + 8'd4);
      8'h2B:         s.value = 6'd62;
      8'h2F:         s.value = 6'd63;
      default:       s.hit   = 1'b0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/bsd_decode.sv
module bsd_decode (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [bsd_pkg::CharW-1:0]     char_code,
  input  logic                          last_char,
  input  logic [bsd_pkg::CapW-1:0]      out_capacity,
  output bsd_pkg::step_out_t            result
);

  logic [5:0]                buffer, buffer_next;
  logic [2:0]                bits_held, bits_held_next;
  logic [1:0]                pad_count, pad_count_next;
  logic                      pad_closed, pad_closed_next;
  logic [bsd_pkg::CapW-1:0]  bytes_done, bytes_done_next;
  logic                      overflowed, overflowed_next;

  bsd_pkg::sextet_t          sx;
  logic [11:0]               acc;
  logic [7:0]                byte_val;
  logic                      ok;

  assign sx  = bsd_pkg::sextet_of(char_code);
  assign acc = {buffer, sx.value};

  always_comb begin
    case (bits_held)
      3'd2:    byte_val = acc[7:0];
      3'd4:    byte_val = acc[9:2];
      default: byte_val = acc[11:4];
    endcase
  end

  always_comb begin
    buffer_next     = buffer;
    bits_held_next  = bits_held;
    pad_count_next  = pad_count;
    pad_closed_next = pad_closed;
    bytes_done_next = bytes_done;
    overflowed_next = overflowed;
    result          = '0;

    if (pad_closed) begin
    end else if (pad_count != 2'd0) begin
      if (char_code == bsd_pkg::PadChar) begin
        pad_count_next = 2'd2;
      end
      pad_closed_next = 1'b1;
    end else if (char_code == bsd_pkg::PadChar) begin
      pad_count_next = 2'd1;
    end else if (sx.hit) begin
      if (bits_held == 3'd0) begin
        bits_held_next = 3'd6;
        buffer_next    = sx.value;
      end else begin
        bits_held_next = bits_held - 3'd2;
        case (bits_held)
          3'd2:    buffer_next = 6'd0;
          3'd4:    buffer_next = {4'd0, acc[1:0]};
          default: buffer_next = {2'd0, acc[3:0]};
        endcase
        if (!overflowed) begin
          if (bytes_done >= out_capacity) begin
            overflowed_next = 1'b1;
          end else begin
            bytes_done_next          = bytes_done + bsd_pkg::CapW'(1);
            result.data_vld          = 1'b1;
            result.data_res.item_kind = bsd_pkg::KindData;
            result.data_res.data_byte = byte_val;
          end
        end
      end
    end

    ok = (pad_count_next == 2'd0 && bits_held_next == 3'd0) ||
         (pad_count_next == 2'd1 && bits_held_next == 3'd2) ||
         (pad_count_next == 2'd2 && bits_held_next == 3'd4);

    if (last_char) begin
      result.stat_vld             = 1'b1;
      result.stat_res.item_kind   = bsd_pkg::KindStatus;
      result.stat_res.byte_total  = bytes_done_next;
      result.stat_res.last_result = 1'b1;
      if (overflowed_next) begin
        result.stat_res.status_code = bsd_pkg::StatOverflow;
      end else if (ok) begin
        result.stat_res.status_code = bsd_pkg::StatOk;
      end else begin
        result.stat_res.status_code = bsd_pkg::StatBadPad;
      end
      buffer_next     = '0;
      bits_held_next  = '0;
      pad_count_next  = '0;
      pad_closed_next = 1'b0;
      bytes_done_next = '0;
      overflowed_next = 1'b0;
    end

    if (!step) begin
      result.data_vld = 1'b0;
      result.stat_vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer     <= '0;
      bits_held  <= '0;
      pad_count  <= '0;
      pad_closed <= 1'b0;
      bytes_done <= '0;
      overflowed <= 1'b0;
    end else if (step) begin
      buffer     <= buffer_next;
      bits_held  <= bits_held_next;
      pad_count  <= pad_count_next;
      pad_closed <= pad_closed_next;
      bytes_done <= bytes_done_next;
      overflowed <= overflowed_next;
    end
  end

endmodule

>>> rtl/base64_stream_decoder_top.sv
// Base64 stream decoder, standard alphabet with '=' padding.
// Input: s_axis carries one character per word, tlast on the final character
// of a message. Output: m_axis carries data bytes (tuser 0) and one status
// word per message (tuser 1, tlast 1) with the status code and byte count.
// Config: cfg_valid/cfg_data write the per-message output capacity; cfg_ready
// is always high. Write it only while no message is in flight.
// Path: an accepted character waits in an input register; the decoder
// consumes it from there and writes its results into the result queue,
// whose head drives m_axis. Throughput: one character per cycle while the
// queue has room; the output moves one word per cycle while m_axis_tready
// is high, and a final character that also yields a byte gives two words.
// A four-entry result queue sets how far the input runs ahead of a stalled
// receiver; s_axis_tready drops once it cannot hold two more results.
// Reset: clears the message state, empties the queue and sets the capacity
// to 65535.
`include "base64_stream_decoder_top_defines.svh"

module base64_stream_decoder_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // char_code[7:0]
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // data_byte[7:0], status_code[9:8], byte_total[25:10], zero[31:26]
  output logic [bsd_pkg::TdataW-1:0]  m_axis_tdata,
  output logic                        m_axis_tuser,   // item_kind
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bsd_pkg::CapW-1:0]    cfg_data
);

  logic [bsd_pkg::CapW-1:0]    out_capacity;
  logic                        in_valid;
  logic [bsd_pkg::CharW-1:0]   in_char;
  logic                        in_last;
  logic                        consume;
  logic                        pop;
  logic                        space;
  bsd_pkg::step_out_t          step_res;

  bsd_pkg::result_t            queue [bsd_pkg::QDepth];
  logic [bsd_pkg::QPtrW-1:0]   head, tail, tail_second;
  logic [bsd_pkg::QCntW-1:0]   count, count_next;
  bsd_pkg::result_t            head_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= bsd_pkg::CapReset;
    end else if (cfg_valid) begin
      out_capacity <= cfg_data;
    end
  end

  assign pop     = m_axis_tvalid && m_axis_tready;
  assign space   = (count <= bsd_pkg::QCntW'(bsd_pkg::QDepth - 2)) ||
                   (count == bsd_pkg::QCntW'(bsd_pkg::QDepth - 1) && pop);
  assign consume = in_valid && space;
  assign s_axis_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  bsd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .step         (consume),
    .char_code    (in_char),
    .last_char    (in_last),
    .out_capacity (out_capacity),
    .result       (step_res)
  );

  assign tail_second = tail + bsd_pkg::QPtrW'(step_res.data_vld);

  always_ff @(posedge clk) begin
    if (step_res.data_vld) begin
      queue[tail] <= step_res.data_res;
    end
    if (step_res.stat_vld) begin
      queue[tail_second] <= step_res.stat_res;
    end
  end

  assign count_next = count
                    + bsd_pkg::QCntW'(step_res.data_vld)
                    + bsd_pkg::QCntW'(step_res.stat_vld)
                    - bsd_pkg::QCntW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + bsd_pkg::QPtrW'(pop);
      tail  <= tail + bsd_pkg::QPtrW'(step_res.data_vld)
                    + bsd_pkg::QPtrW'(step_res.stat_vld);
      count <= count_next;
    end
  end

  assign head_res      = queue[head];
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {6'd0, head_res.byte_total, head_res.status_code,
                          head_res.data_byte};
  assign m_axis_tuser  = head_res.item_kind;
  assign m_axis_tlast  = head_res.last_result;

  `BSD_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1,
                  count <= bsd_pkg::QCntW'(bsd_pkg::QDepth))
  `BSD_ASSERT_NOW(a_status_on_last, clk, rst, step_res.stat_vld,
                  consume && in_last && step_res.stat_res.last_result)
  `BSD_ASSERT_NEXT(a_status_visible, clk, rst,
                   step_res.stat_vld && count == '0 && !step_res.data_vld,
                   m_axis_tvalid && m_axis_tlast)

endmodule
